FILE: rtl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types and constants of the residual systematic resampler: field
// widths, configuration register indexes and reset values, stage payloads.
// ----------------------------------------------------------------------------
package rsr_pkg;

    // Field widths
    localparam int COUNT_W  = 13;   // particle_count, block_length, block_count
    localparam int BNUM_W   = 13;
    localparam int OFFSET_W = 15;
    localparam int WEIGHT_W = 15;
    localparam int ADDR_W   = 12;
    localparam int REP_W    = 13;
    localparam int PROD_W   = WEIGHT_W + COUNT_W;   // weight * particle_count
    localparam int SPAN_W   = BNUM_W + COUNT_W;     // block number * block length

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PARTICLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT    = 2'd2;

    // Configuration reset values
    localparam logic [COUNT_W-1:0] PARTICLE_COUNT_RST = 13'd4096;
    localparam logic [COUNT_W-1:0] BLOCK_LENGTH_RST   = 13'd128;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST    = 13'd32;

    typedef struct packed {
        logic [COUNT_W-1:0] particle_count;
        logic [COUNT_W-1:0] block_length;
        logic [COUNT_W-1:0] block_count;
    } cfg_t;

    // One input transaction as held in the input register
    typedef struct packed {
        logic                first;
        logic [BNUM_W-1:0]   block_number;
        logic [OFFSET_W-1:0] initial_offset;
        logic [WEIGHT_W-1:0] weight;
    } item_t;

    // Item after the multipliers
    typedef struct packed {
        logic                first;
        logic                bnum_ok;       // 1 <= block_number <= block_count
        logic [SPAN_W-1:0]   block_start;   // (block_number-1) * block_length
        logic [SPAN_W-1:0]   block_stop;    // block_number * block_length
        logic [OFFSET_W-1:0] initial_offset;
        logic [PROD_W-1:0]   product;       // weight * particle_count
    } decoded_t;

    // One result record
    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [ADDR_W-1:0] particle_index;
        logic [REP_W-1:0]  replication;
        logic              last;
    } result_t;

endpackage

FILE: rtl/rsr_if.sv
// ----------------------------------------------------------------------------
// rsr_if
// Channel interfaces of the resampler: weight items, index records and
// configuration writes, each with valid/ready.
// ----------------------------------------------------------------------------

// Weight item channel
interface rsr_item_if;
    logic                                valid;
    logic                                ready;
    logic                                first;
    logic [rsr_pkg::BNUM_W-1:0]          block_number;
    logic [rsr_pkg::OFFSET_W-1:0]        initial_offset;
    logic [rsr_pkg::WEIGHT_W-1:0]        weight;

    modport source (output valid, first, block_number, initial_offset, weight,
                    input ready);
    modport sink   (input valid, first, block_number, initial_offset, weight,
                    output ready);
endinterface

// Index record channel
interface rsr_result_if;
    logic                                valid;
    logic                                ready;
    logic [rsr_pkg::ADDR_W-1:0]          write_address;
    logic [rsr_pkg::ADDR_W-1:0]          particle_index;
    logic [rsr_pkg::REP_W-1:0]           replication;
    logic                                last;

    modport source (output valid, write_address, particle_index, replication, last,
                    input ready);
    modport sink   (input valid, write_address, particle_index, replication, last,
                    output ready);
endinterface

// Configuration write channel
interface rsr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rsr_pkg::CFG_INDEX_W-1:0]     index;
    logic [rsr_pkg::COUNT_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/residual_systematic_resampler_top.sv
// ----------------------------------------------------------------------------
// residual_systematic_resampler_top
// Residual systematic resampling of one particle block per opening item,
// one index record per particle of the block.
// ----------------------------------------------------------------------------
// The block takes one weight item every clock cycle while the sink takes the
// records, and passes it through the input register, the multiplier stage and
// the result register of the update stage, in that order. Throughput is one
// item per cycle under the same condition; it is set by the residual offset
// recurrence, which closes within the single update stage (one add of the
// weight product, the offset and 2^SCALE_BITS). A record held back by the sink
// stalls the update stage, and the input once both earlier registers are full.
// An item with first = 1 opens block block_number, loads initial_offset and is
// itself the block's first particle; an invalid block number or an item
// while no block is open produces no record. Kept particles are written
// upward from the block start, discarded ones with replication 0 downward
// from the block end. Configuration writes are accepted at any time but must
// only be issued while the pipeline is empty.
// ----------------------------------------------------------------------------
module residual_systematic_resampler_top #(
    parameter int MAX_PARTICLES = 4096,
    parameter int SCALE_BITS    = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    rsr_item_if.sink          items,
    rsr_result_if.source      results,
    rsr_cfg_if.sink           cfg
);

    rsr_pkg::cfg_t      cfg_val;
    rsr_pkg::item_t     in_item;
    rsr_pkg::item_t     a_item;
    logic               a_valid;
    logic               a_ready;
    rsr_pkg::decoded_t  b_item;
    logic               b_valid;
    logic               b_ready;
    rsr_pkg::result_t   res_item;

    // Pack the incoming fields
    assign in_item.first          = items.first;
    assign in_item.block_number   = items.block_number;
    assign in_item.initial_offset = items.initial_offset;
    assign in_item.weight         = items.weight;

    rsr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    rsr_input_stage u_input_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (items.valid),
        .up_ready (items.ready),
        .up_item  (in_item),
        .dn_valid (a_valid),
        .dn_ready (a_ready),
        .dn_item  (a_item)
    );

    rsr_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_val),
        .up_valid (a_valid),
        .up_ready (a_ready),
        .up_item  (a_item),
        .dn_valid (b_valid),
        .dn_ready (b_ready),
        .dn_item  (b_item)
    );

    rsr_update #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .SCALE_BITS    (SCALE_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_val),
        .up_valid  (b_valid),
        .up_ready  (b_ready),
        .up_item   (b_item),
        .res_valid (results.valid),
        .res_ready (results.ready),
        .res_item  (res_item)
    );

    // Unpack the record
    assign results.write_address  = res_item.write_address;
    assign results.particle_index = res_item.particle_index;
    assign results.replication    = res_item.replication;
    assign results.last           = res_item.last;

endmodule

FILE: rtl/rsr_cfg_regs.sv
// ----------------------------------------------------------------------------
// rsr_cfg_regs
// Configuration register file: particle count, block length, block count.
// Always ready; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module rsr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_valid,
    output logic                            wr_ready,
    input  logic [rsr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [rsr_pkg::COUNT_W-1:0]     wr_data,
    output rsr_pkg::cfg_t                   cfg
);

    rsr_pkg::cfg_t cfg_reg;
    rsr_pkg::cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                rsr_pkg::REG_PARTICLE_COUNT: cfg_next.particle_count = wr_data;
                rsr_pkg::REG_BLOCK_LENGTH:   cfg_next.block_length   = wr_data;
                rsr_pkg::REG_BLOCK_COUNT:    cfg_next.block_count    = wr_data;
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.particle_count <= rsr_pkg::PARTICLE_COUNT_RST;
            cfg_reg.block_length   <= rsr_pkg::BLOCK_LENGTH_RST;
            cfg_reg.block_count    <= rsr_pkg::BLOCK_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/rsr_input_stage.sv
// ----------------------------------------------------------------------------
// rsr_input_stage
// Input register: captures one weight item per cycle, holds it while the
// decode stage is stalled.
// ----------------------------------------------------------------------------
module rsr_input_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  rsr_pkg::item_t  up_item,
    output logic            dn_valid,
    input  logic            dn_ready,
    output rsr_pkg::item_t  dn_item
);

    logic           valid_reg;
    logic           valid_next;
    rsr_pkg::item_t item_reg;
    logic           load;

    // Stage frees up whenever the next one takes the held item
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= up_item;
        end
    end

endmodule

FILE: rtl/rsr_decode.sv
// ----------------------------------------------------------------------------
// rsr_decode
// Decode stage: forms weight*particle_count and the block span products
// (block_number-1)*block_length and block_number*block_length, and checks
// the block number against block_count.
// ----------------------------------------------------------------------------
module rsr_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  rsr_pkg::cfg_t      cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  rsr_pkg::item_t     up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output rsr_pkg::decoded_t  dn_item
);

    logic                          valid_reg;
    logic                          valid_next;
    rsr_pkg::decoded_t             item_reg;
    rsr_pkg::decoded_t             item_next;
    logic [rsr_pkg::BNUM_W-1:0]    bnum_m1;
    logic                          load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    // Multipliers and block number check
    always_comb
    begin
        bnum_m1                  = up_item.block_number - rsr_pkg::BNUM_W'(1);
        item_next.first          = up_item.first;
        item_next.bnum_ok        = (up_item.block_number != '0) &&
                                   (up_item.block_number <= cfg.block_count);
        item_next.block_start    = rsr_pkg::SPAN_W'(bnum_m1 * cfg.block_length);
        item_next.block_stop     = rsr_pkg::SPAN_W'(up_item.block_number * cfg.block_length);
        item_next.initial_offset = up_item.initial_offset;
        item_next.product        = rsr_pkg::PROD_W'(up_item.weight * cfg.particle_count);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/rsr_update.sv
// ----------------------------------------------------------------------------
// rsr_update
// Update stage: block state, offset recurrence, kept/discarded pointers and
// the result register. One item is handled per cycle while the result register is free.
// ----------------------------------------------------------------------------
module rsr_update #(
    parameter int MAX_PARTICLES = 4096,
    parameter int SCALE_BITS    = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rsr_pkg::cfg_t      cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  rsr_pkg::decoded_t  up_item,
    output logic               res_valid,
    input  logic               res_ready,
    output rsr_pkg::result_t   res_item
);

    // Offset width: the loaded offset or a residual in 1..2^SCALE_BITS
    localparam int UW = (SCALE_BITS + 1 > rsr_pkg::OFFSET_W) ? SCALE_BITS + 1
                                                              : rsr_pkg::OFFSET_W;
    // Signed width of t + 2^SCALE_BITS
    localparam int VW = ((rsr_pkg::PROD_W > UW) ? rsr_pkg::PROD_W : UW) + 2;
    localparam int FW = VW - SCALE_BITS;
    localparam int CW = rsr_pkg::COUNT_W;
    localparam int AW = rsr_pkg::ADDR_W;
    localparam logic [VW-1:0]         SCALE_ONE_V = VW'(64'd1 << SCALE_BITS);
    localparam logic [SCALE_BITS:0]   SCALE_ONE_S = (SCALE_BITS + 1)'(64'd1 << SCALE_BITS);
    localparam logic [31:0]           REP_MAX     = 32'(MAX_PARTICLES);

    // Block state
    logic          active_reg,  active_next;
    logic [UW-1:0] offset_reg,  offset_next;
    logic [AW-1:0] upper_reg,   upper_next;
    logic [AW-1:0] lower_reg,   lower_next;
    logic [CW-1:0] current_reg, current_next;
    logic [CW-1:0] end_reg,     end_next;

    // Result register
    logic              res_valid_reg, res_valid_next;
    rsr_pkg::result_t  res_reg,       res_next;

    logic          res_free;
    logic          take;
    logic          span_ok;
    logic          open_blk;
    logic          handle;
    logic [CW-1:0] from_c;
    logic [CW-1:0] to_c;
    logic [CW-1:0] cur_use;
    logic [CW-1:0] end_use;
    logic [AW-1:0] upper_use;
    logic [AW-1:0] lower_use;
    logic [UW-1:0] u_use;
    logic [VW-1:0] v;
    logic          keep;
    logic [FW-1:0] fact;
    logic [31:0]   fact_w;
    logic [31:0]   rep_sat;
    logic [SCALE_BITS:0] u_new;
    logic          is_last;

    assign res_free  = !res_valid_reg || res_ready;
    assign up_ready  = res_free;
    assign take      = up_valid && res_free;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // Block span check and bounds
    always_comb
    begin
        span_ok  = up_item.bnum_ok && (cfg.block_length != '0) &&
                   (up_item.block_start < rsr_pkg::SPAN_W'(cfg.particle_count));
        from_c   = up_item.block_start[CW-1:0];
        if (up_item.block_stop <= rsr_pkg::SPAN_W'(cfg.particle_count))
        begin
            to_c = up_item.block_stop[CW-1:0] - CW'(1);
        end
        else
        begin
            to_c = cfg.particle_count - CW'(1);
        end
        open_blk  = up_item.first && span_ok;
        handle    = open_blk || (!up_item.first && active_reg);
        cur_use   = open_blk ? from_c          : current_reg;
        end_use   = open_blk ? to_c            : end_reg;
        upper_use = open_blk ? from_c[AW-1:0]  : upper_reg;
        lower_use = open_blk ? to_c[AW-1:0]    : lower_reg;
        u_use     = open_blk ? UW'(up_item.initial_offset) : offset_reg;
        is_last   = (cur_use == end_use);
    end

    // Offset recurrence: v = w*count - u + 2^S, fact = floor(v / 2^S)
    always_comb
    begin
        v       = VW'(up_item.product) + SCALE_ONE_V - VW'(u_use);
        keep    = !v[VW-1] && (|v[VW-2:SCALE_BITS]);
        fact    = v[VW-1:SCALE_BITS];
        fact_w  = 32'(fact);
        rep_sat = (fact_w > REP_MAX) ? REP_MAX : fact_w;
        u_new   = SCALE_ONE_S - {1'b0, v[SCALE_BITS-1:0]};
    end

    // State and result next values
    always_comb
    begin
        active_next    = active_reg;
        offset_next    = offset_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        current_next   = current_reg;
        end_next       = end_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (res_free)
        begin
            res_valid_next = take && handle;
        end

        if (take)
        begin
            if (up_item.first)
            begin
                active_next = 1'b0;
            end
            if (handle)
            begin
                offset_next  = UW'(u_new);
                current_next = cur_use + CW'(1);
                end_next     = end_use;
                active_next  = !is_last;
                res_next.particle_index = cur_use[AW-1:0];
                res_next.last           = is_last;
                if (keep)
                begin
                    res_next.write_address = upper_use;
                    res_next.replication   = rep_sat[rsr_pkg::REP_W-1:0];
                    upper_next             = upper_use + AW'(1);
                    lower_next             = lower_use;
                end
                else
                begin
                    res_next.write_address = lower_use;
                    res_next.replication   = '0;
                    upper_next             = upper_use;
                    lower_next             = lower_use - AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            offset_reg    <= '0;
            upper_reg     <= '0;
            lower_reg     <= '0;
            current_reg   <= '0;
            end_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            offset_reg    <= offset_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            current_reg   <= current_next;
            end_reg       <= end_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // An open block never runs past its final particle
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (current_reg <= end_reg))
        else $error("rsr_update: current particle beyond block end");

    // The final record of a block closes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && handle && is_last) |=> !active_reg)
        else $error("rsr_update: block still open after its last record");

    // After a handled item the residual lies in 1..2^SCALE_BITS
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && handle) |=> ((offset_reg != '0) && (offset_reg <= UW'(SCALE_ONE_S))))
        else $error("rsr_update: residual offset out of range");

    // A record is produced exactly for handled items
    assert property (@(posedge clk) disable iff (!rst_n)
        res_free |=> (res_valid_reg == $past(take && handle)))
        else $error("rsr_update: result valid does not match handled item");

endmodule
